// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Each macro expands to one labeled
// concurrent assertion clocked by i_clk and disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ECDF_ASSERT_IMP(lbl, cond, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error("same-cycle check failed");

// Next-cycle implication.
`define ECDF_ASSERT_NXT(lbl, cond, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error("next-cycle check failed");

`endif

// File: rtl/ecdf_pkg.sv
// ----------------------------------------------------------------------------
// ecdf_pkg
// Shared constants of the empirical CDF table lookup core: field widths,
// operation and status codes, register indexes and divider sizing.
// ----------------------------------------------------------------------------
package ecdf_pkg;

    localparam int DEF_TABLE_DEPTH = 1024;

    localparam int VAL_W    = 32;
    localparam int PROB_W   = 17;
    localparam int KEY_W    = 33;
    localparam int OP_W     = 3;
    localparam int EIDX_W   = 10;
    localparam int STATUS_W = 2;
    localparam int CNT_REG_W = 11;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 17;

    localparam int IN_TDATA_W  = 96;
    localparam int IN_TUSER_W  = 4;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_TUSER_W = 2;

    localparam logic [PROB_W-1:0] ONE_Q16 = 17'd65536;

    // Restoring divider: dividend bits, divisor bits, step counter bits.
    localparam int DIV_NW = 50;
    localparam int DIV_DW = 34;
    localparam int DIV_CW = 6;

    localparam logic [OP_W-1:0] OP_WRITE    = 3'd0;
    localparam logic [OP_W-1:0] OP_VALIDATE = 3'd1;
    localparam logic [OP_W-1:0] OP_FILL     = 3'd2;
    localparam logic [OP_W-1:0] OP_V2P      = 3'd3;
    localparam logic [OP_W-1:0] OP_P2V      = 3'd4;
    localparam logic [OP_W-1:0] OP_MEAN     = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLOT_OFFSET = 1'b1;

endpackage

// File: rtl/empirical_cdf_table_lookup_core.sv
// ----------------------------------------------------------------------------
// empirical_cdf_table_lookup_core
// Table of sorted value/probability pairs with write, validate, plotting
// position fill, interpolated lookups in both directions and a window mean.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake               Payload
//  -------   ---------  ---------------------   ---------------------------
//  s_axis    in         tvalid / tready         command word, tdata + tuser
//  m_axis    out        tvalid / tready         result word, tdata + tuser
//  cfg       in         i_cfg_we (no wait)      entry_count, plotting_offset
//
//  A command word runs to completion before the next one is accepted. Validate
//  and window mean walk the entries in use; a lookup searches and then uses
//  the 50-step shared divider, as fill does once per entry. One shared
//  restoring divider and one table read port do all of the work.
//  Reset is synchronous and clears control state and table_valid; the table
//  memories are not cleared. A result that waits in the output register does
//  not block the next command word; the next result waits for it.
//
module empirical_cdf_table_lookup_core #(
    parameter int TABLE_DEPTH = ecdf_pkg::DEF_TABLE_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ecdf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ecdf_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [9:0] entry_index, [41:10] data_value, [58:42] probability,
    // [75:59] window_low, [92:76] window_high, [95:93] zero
    input  logic [ecdf_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // [2:0] opcode, [3] null_outside
    input  logic [ecdf_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [31:0] result_value
    output logic [ecdf_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // [1:0] status
    output logic [ecdf_pkg::OUT_TUSER_W-1:0]   m_axis_tuser
);
    import ecdf_pkg::*;

    localparam int IW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW    = IW + 1;
    localparam int SUM_W = VAL_W + IW + 1;

    typedef enum logic [14:0] {
        S_IDLE     = 15'b000000000000001,
        S_VAL      = 15'b000000000000010,
        S_FILL_LD  = 15'b000000000000100,
        S_FILL_WR  = 15'b000000000001000,
        S_LK_0     = 15'b000000000010000,
        S_LK_N     = 15'b000000000100000,
        S_LK_SRCH  = 15'b000000001000000,
        S_LK_CMP   = 15'b000000010000000,
        S_LK_MUL   = 15'b000000100000000,
        S_LK_LD    = 15'b000001000000000,
        S_MEAN     = 15'b000010000000000,
        S_MEAN_END = 15'b000100000000000,
        S_DIV      = 15'b001000000000000,
        S_POST     = 15'b010000000000000,
        S_DONE     = 15'b100000000000000
    } t_state;

    // Control registers.
    t_state                 r_state, n_state;
    logic [CNT_REG_W-1:0]   r_entry_count, n_entry_count;
    logic [PROB_W-1:0]      r_offset, n_offset;
    logic                   r_valid, n_valid;
    logic                   r_out_valid, n_out_valid;
    logic [DIV_CW-1:0]      r_dcnt, n_dcnt;
    logic [CW-1:0]          r_idx, n_idx;

    // Working payload registers.
    logic [OP_W-1:0]        r_op, n_op;
    logic                   r_null, n_null;
    logic signed [KEY_W-1:0] r_q, n_q;
    logic [PROB_W-1:0]      r_wlo, n_wlo, r_whi, n_whi;
    logic [IW-1:0]          r_lo, n_lo, r_hi, n_hi, r_mid, n_mid;
    logic signed [KEY_W-1:0] r_xs, n_xs, r_xe, n_xe, r_ys, n_ys, r_ye, n_ye;
    logic [48:0]            r_prod, n_prod;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic                   r_neg, n_neg;
    logic                   r_ok, n_ok;
    logic signed [VAL_W-1:0] r_prev_v, n_prev_v;
    logic [PROB_W-1:0]      r_prev_p, n_prev_p;
    logic [DIV_NW-1:0]      r_quo, n_quo;
    logic [DIV_DW-1:0]      r_rem, n_rem, r_dsr, n_dsr;
    logic [VAL_W-1:0]       r_res, n_res, r_out_value, n_out_value;
    logic [STATUS_W-1:0]    r_st, n_st, r_out_status, n_out_status;

    // Table memories with registered read data.
    logic signed [VAL_W-1:0] r_vmem [TABLE_DEPTH];
    logic [PROB_W-1:0]       r_pmem [TABLE_DEPTH];
    logic signed [VAL_W-1:0] r_vrd;
    logic [PROB_W-1:0]       r_prd;
    logic [IW-1:0]           n_raddr;
    logic                    w_we_v, w_we_p;
    logic [IW-1:0]           w_waddr;
    logic [VAL_W-1:0]        w_wv;
    logic [PROB_W-1:0]       w_wp;

    // Decoded command fields.
    logic [OP_W-1:0]         in_op;
    logic [EIDX_W-1:0]       in_idx;
    logic [VAL_W-1:0]        in_val;
    logic [PROB_W-1:0]       in_prob;
    logic                    in_accept, in_idx_ok;

    // Combinational helpers.
    logic [CW-1:0]           w_n, w_nm1;
    logic [PROB_W-1:0]       w_a;
    logic [DIV_DW-1:0]       w_fden, w_fnum;
    logic signed [KEY_W-1:0] d_key, d_oth;
    logic signed [KEY_W:0]   w_dx, w_dy, w_dd;
    logic [16:0]             w_small;
    logic [31:0]             w_big;
    logic [IW-1:0]           w_midx;
    logic signed [SUM_W-1:0] w_vext;
    logic [SUM_W-1:0]        w_mag;
    logic [DIV_DW:0]         w_trial;
    logic                    w_qbit;

    assign in_op     = s_axis_tuser[2:0];
    assign in_idx    = s_axis_tdata[9:0];
    assign in_val    = s_axis_tdata[41:10];
    assign in_prob   = s_axis_tdata[58:42];
    assign in_idx_ok = ({22'd0, in_idx} < 32'(TABLE_DEPTH));
    assign in_accept = s_axis_tvalid && (r_state == S_IDLE);

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_value;
    assign m_axis_tuser  = r_out_status;

    // Entries in use saturate at the table depth; the offset saturates at one.
    assign w_n   = (32'(r_entry_count) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                           : CW'(r_entry_count);
    assign w_nm1 = w_n - CW'(1);
    assign w_a   = (r_offset > ONE_Q16) ? ONE_Q16 : r_offset;
    assign w_fden = ((DIV_DW'(w_n) + DIV_DW'(1)) << 16) - (DIV_DW'(w_a) << 1);
    assign w_fnum = ((DIV_DW'(r_idx) + DIV_DW'(1)) << 16) - DIV_DW'(w_a);

    // The search key is the value column for value-to-probability lookups
    // and the probability column for the reverse direction.
    assign d_key = (r_op == OP_P2V) ? $signed({16'd0, r_prd}) : $signed({r_vrd[31], r_vrd});
    assign d_oth = (r_op == OP_P2V) ? $signed({r_vrd[31], r_vrd}) : $signed({16'd0, r_prd});

    // Interpolation terms. On a validated table the probability difference
    // fits 17 bits and the value difference 32 bits.
    assign w_dx    = r_q - r_xs;
    assign w_dy    = r_ye - r_ys;
    assign w_dd    = r_xe - r_xs;
    assign w_small = (r_op == OP_P2V) ? w_dx[16:0] : w_dy[16:0];
    assign w_big   = (r_op == OP_P2V) ? w_dy[31:0] : w_dx[31:0];
    assign w_midx  = r_lo + IW'((r_hi - r_lo) >> 1);

    assign w_vext = {{(SUM_W-VAL_W){r_vrd[31]}}, r_vrd};
    assign w_mag  = r_sum[SUM_W-1] ? (~r_sum + SUM_W'(1)) : r_sum;

    // One step of the restoring divider.
    assign w_trial = {r_rem, r_quo[DIV_NW-1]};
    assign w_qbit  = (w_trial >= {1'b0, r_dsr});

    always_comb begin
        n_state       = r_state;
        n_entry_count = r_entry_count;
        n_offset      = r_offset;
        n_valid       = r_valid;
        n_out_valid   = r_out_valid;
        n_dcnt        = r_dcnt;
        n_idx         = r_idx;
        n_op          = r_op;
        n_null        = r_null;
        n_q           = r_q;
        n_wlo         = r_wlo;
        n_whi         = r_whi;
        n_lo          = r_lo;
        n_hi          = r_hi;
        n_mid         = r_mid;
        n_xs          = r_xs;
        n_xe          = r_xe;
        n_ys          = r_ys;
        n_ye          = r_ye;
        n_prod        = r_prod;
        n_sum         = r_sum;
        n_cnt         = r_cnt;
        n_neg         = r_neg;
        n_ok          = r_ok;
        n_prev_v      = r_prev_v;
        n_prev_p      = r_prev_p;
        n_quo         = r_quo;
        n_rem         = r_rem;
        n_dsr         = r_dsr;
        n_res         = r_res;
        n_st          = r_st;
        n_out_value   = r_out_value;
        n_out_status  = r_out_status;
        n_raddr       = '0;
        w_we_v        = 1'b0;
        w_we_p        = 1'b0;
        w_waddr       = '0;
        w_wv          = '0;
        w_wp          = '0;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_op   = in_op;
                    n_null = s_axis_tuser[3];
                    n_q    = (in_op == OP_P2V) ? $signed({16'd0, in_prob})
                                               : $signed({in_val[31], in_val});
                    n_wlo  = s_axis_tdata[75:59];
                    n_whi  = s_axis_tdata[92:76];
                    n_res  = '0;
                    n_st   = ST_OK;
                    n_idx  = '0;
                    n_state = S_DONE;
                    case (in_op)
                        OP_WRITE: begin
                            if (in_idx_ok) begin
                                w_we_v  = 1'b1;
                                w_we_p  = 1'b1;
                                w_waddr = IW'(in_idx);
                                w_wv    = in_val;
                                w_wp    = in_prob;
                                n_valid = 1'b0;
                            end
                        end
                        OP_VALIDATE: begin
                            if (w_n == '0) begin
                                n_valid = 1'b0;
                                n_st    = ST_INVALID;
                            end else begin
                                n_ok    = 1'b1;
                                n_state = S_VAL;
                            end
                        end
                        OP_FILL: begin
                            if (w_n == '0) begin
                                n_st = ST_OK;
                            end else if (w_fden == '0) begin
                                n_st = ST_EMPTY;
                            end else begin
                                n_dsr   = w_fden;
                                n_state = S_FILL_LD;
                            end
                        end
                        OP_V2P, OP_P2V: begin
                            if (!r_valid || (w_n == '0)) begin
                                n_st = ST_INVALID;
                            end else begin
                                n_state = S_LK_0;
                            end
                        end
                        OP_MEAN: begin
                            n_sum = '0;
                            n_cnt = '0;
                            n_state = (w_n == '0) ? S_MEAN_END : S_MEAN;
                        end
                        default: begin
                            n_st = ST_OK;
                        end
                    endcase
                end
            end

            S_VAL: begin
                if (r_prd > ONE_Q16) begin
                    n_ok = 1'b0;
                end
                if ((r_idx != '0) && ((r_vrd < r_prev_v) || (r_prd < r_prev_p))) begin
                    n_ok = 1'b0;
                end
                n_prev_v = r_vrd;
                n_prev_p = r_prd;
                if (r_idx == w_nm1) begin
                    n_valid = n_ok;
                    n_st    = n_ok ? ST_OK : ST_INVALID;
                    n_state = S_DONE;
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_raddr = n_idx[IW-1:0];
                end
            end

            S_FILL_LD: begin
                n_quo   = (DIV_NW'(w_fnum) << 16) + DIV_NW'(r_dsr >> 1);
                n_rem   = '0;
                n_dcnt  = '0;
                n_state = S_DIV;
            end

            S_FILL_WR: begin
                w_we_p  = 1'b1;
                w_waddr = r_idx[IW-1:0];
                w_wp    = r_quo[PROB_W-1:0];
                if (r_idx == w_nm1) begin
                    n_st    = ST_OK;
                    n_state = S_DONE;
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_state = S_FILL_LD;
                end
            end

            S_LK_0: begin
                // Hold the read on entry zero.
                n_raddr = '0;
                n_state = S_LK_N;
            end

            S_LK_N: begin
                // First entry arrives here; the last entry follows next cycle.
                n_xs    = d_key;
                n_ys    = d_oth;
                n_lo    = '0;
                n_hi    = w_nm1[IW-1:0];
                n_raddr = w_nm1[IW-1:0];
                n_idx   = '0;
                n_state = S_LK_CMP;
                n_mid   = w_nm1[IW-1:0];
                n_cnt   = '1;
            end

            S_LK_CMP: begin
                if (r_cnt != '0) begin
                    // Last entry: range checks against both ends.
                    n_cnt = '0;
                    n_xe  = d_key;
                    n_ye  = d_oth;
                    if (r_q < r_xs) begin
                        n_res   = r_null ? '0 : r_ys[31:0];
                        n_st    = r_null ? ST_OUTSIDE : ST_OK;
                        n_state = S_DONE;
                    end else if (r_q > d_key) begin
                        n_res   = r_null ? '0 : d_oth[31:0];
                        n_st    = r_null ? ST_OUTSIDE : ST_OK;
                        n_state = S_DONE;
                    end else if (r_q == r_xs) begin
                        n_res   = r_ys[31:0];
                        n_st    = ST_OK;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_LK_SRCH;
                    end
                end else begin
                    if (r_q <= d_key) begin
                        n_hi = r_mid;
                        n_xe = d_key;
                        n_ye = d_oth;
                    end else begin
                        n_lo = r_mid;
                        n_xs = d_key;
                        n_ys = d_oth;
                    end
                    n_state = S_LK_SRCH;
                end
            end

            S_LK_SRCH: begin
                if (({1'b0, r_lo} + CW'(1)) < {1'b0, r_hi}) begin
                    n_mid   = w_midx;
                    n_raddr = w_midx;
                    n_state = S_LK_CMP;
                end else begin
                    n_state = S_LK_MUL;
                end
            end

            S_LK_MUL: begin
                n_prod = 49'(w_small) * 49'(w_big);
                n_dsr  = w_dd[DIV_DW-1:0];
                if ((r_xe <= r_xs) || (r_ye < r_ys) || (r_q < r_xs)) begin
                    n_res   = r_ys[31:0];
                    n_st    = ST_OK;
                    n_state = S_DONE;
                end else begin
                    n_state = S_LK_LD;
                end
            end

            S_LK_LD: begin
                n_quo   = DIV_NW'(r_prod) + DIV_NW'(r_dsr >> 1);
                n_rem   = '0;
                n_dcnt  = '0;
                n_state = S_DIV;
            end

            S_MEAN: begin
                if ((r_whi < ONE_Q16) && (r_prd >= r_whi)) begin
                    n_state = S_MEAN_END;
                end else begin
                    if (r_prd >= r_wlo) begin
                        n_sum = r_sum + w_vext;
                        n_cnt = r_cnt + CW'(1);
                    end
                    if (r_idx == w_nm1) begin
                        n_state = S_MEAN_END;
                    end else begin
                        n_idx   = r_idx + CW'(1);
                        n_raddr = n_idx[IW-1:0];
                    end
                end
            end

            S_MEAN_END: begin
                if (r_cnt == '0) begin
                    n_res   = '0;
                    n_st    = ST_EMPTY;
                    n_state = S_DONE;
                end else begin
                    n_neg   = r_sum[SUM_W-1];
                    n_quo   = DIV_NW'(w_mag) + DIV_NW'(r_cnt >> 1);
                    n_dsr   = DIV_DW'(r_cnt);
                    n_rem   = '0;
                    n_dcnt  = '0;
                    n_state = S_DIV;
                end
            end

            S_DIV: begin
                n_rem  = w_qbit ? DIV_DW'(w_trial - {1'b0, r_dsr}) : w_trial[DIV_DW-1:0];
                n_quo  = {r_quo[DIV_NW-2:0], w_qbit};
                n_dcnt = r_dcnt + DIV_CW'(1);
                if (r_dcnt == DIV_CW'(DIV_NW - 1)) begin
                    n_state = S_POST;
                end
            end

            S_POST: begin
                n_st    = ST_OK;
                n_state = S_DONE;
                case (r_op)
                    OP_FILL: begin
                        n_state = S_FILL_WR;
                    end
                    OP_V2P, OP_P2V: begin
                        n_res = 32'(r_ys + $signed({1'b0, r_quo[32:0]}));
                    end
                    OP_MEAN: begin
                        n_res = r_neg ? (~r_quo[31:0] + 32'd1) : r_quo[31:0];
                    end
                    default: begin
                        n_res = '0;
                    end
                endcase
            end

            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = r_res;
                    n_out_status = r_st;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A validate pass starts its read stream at entry zero, as do the
        // mean walk and the first lookup read.
        if (in_accept) begin
            n_raddr = '0;
        end

        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ENTRY_COUNT: begin
                    n_entry_count = i_cfg_data[CNT_REG_W-1:0];
                    n_valid       = 1'b0;
                end
                CFG_PLOT_OFFSET: begin
                    n_offset = i_cfg_data;
                end
                default: begin
                    n_offset = r_offset;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_entry_count <= '0;
            r_offset      <= '0;
            r_valid       <= 1'b0;
            r_out_valid   <= 1'b0;
            r_dcnt        <= '0;
            r_idx         <= '0;
            r_cnt         <= '0;
        end else begin
            r_state       <= n_state;
            r_entry_count <= n_entry_count;
            r_offset      <= n_offset;
            r_valid       <= n_valid;
            r_out_valid   <= n_out_valid;
            r_dcnt        <= n_dcnt;
            r_idx         <= n_idx;
            r_cnt         <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_null       <= n_null;
        r_q          <= n_q;
        r_wlo        <= n_wlo;
        r_whi        <= n_whi;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_mid        <= n_mid;
        r_xs         <= n_xs;
        r_xe         <= n_xe;
        r_ys         <= n_ys;
        r_ye         <= n_ye;
        r_prod       <= n_prod;
        r_sum        <= n_sum;
        r_neg        <= n_neg;
        r_ok         <= n_ok;
        r_prev_v     <= n_prev_v;
        r_prev_p     <= n_prev_p;
        r_quo        <= n_quo;
        r_rem        <= n_rem;
        r_dsr        <= n_dsr;
        r_res        <= n_res;
        r_st         <= n_st;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
    end

    always_ff @(posedge i_clk) begin
        if (w_we_v) begin
            r_vmem[w_waddr] <= w_wv;
        end
        r_vrd <= r_vmem[n_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_we_p) begin
            r_pmem[w_waddr] <= w_wp;
        end
        r_prd <= r_pmem[n_raddr];
    end

`include "assert_macros.svh"

    `ECDF_ASSERT_IMP(a_div_rem_below_divisor, r_state == S_DIV, r_rem < r_dsr)
    `ECDF_ASSERT_NXT(a_div_ends_in_post, (r_state == S_DIV) && (r_dcnt == DIV_CW'(DIV_NW - 1)), r_state == S_POST)
    `ECDF_ASSERT_NXT(a_done_loads_output, (r_state == S_DONE) && !r_out_valid, r_out_valid)
    `ECDF_ASSERT_NXT(a_write_clears_valid, in_accept && (in_op == OP_WRITE) && in_idx_ok, !r_valid)

endmodule
